@@ hw/rtl/vfdr_pkg.sv @@
// ----------------------------------------------------------------------------
// vfdr_pkg
// Shared types and constants for the display grid scan refresher: request and
// result words, the classified command that crosses the queue, and codes.
// ----------------------------------------------------------------------------
package vfdr_pkg;

  // Default geometry of the display.
  localparam int DEF_NUM_GRIDS      = 40;
  localparam int DEF_BYTES_PER_GRID = 5;

  // Grid index field in a command, wide enough for the largest display.
  localparam int GRID_IDX_W = 6;

  // Stored brightness width and values.
  localparam int             BRIGHT_W     = 7;
  localparam logic [7:0]     BRIGHT_MAX8  = 8'd100;
  localparam logic [6:0]     BRIGHT_RESET = 7'd100;
  // Blanking compare is (100 - brightness) + 15.
  localparam logic [6:0]     PWM_TOP      = 7'd115;
  localparam logic [7:0]     ALL_GRIDS    = 8'd99;

  // Frame byte constants.
  localparam logic [7:0] FILL_LIT_BYTE0 = 8'h07;
  localparam logic [7:0] BLINK_MASK     = 8'h08;
  localparam logic [7:0] GRID_SEL_MSB   = 8'h80;
  localparam int         BLINK_BIT      = 3;

  // Depth of the command queue between front and back.
  localparam int QUEUE_DEPTH = 4;

  // Request codes on the input word.
  localparam logic [2:0] REQ_TICK   = 3'd0;
  localparam logic [2:0] REQ_FLUSH  = 3'd1;
  localparam logic [2:0] REQ_BRIGHT = 3'd2;
  localparam logic [2:0] REQ_BLINK  = 3'd3;
  localparam logic [2:0] REQ_FILL   = 3'd4;
  localparam logic [2:0] REQ_WRITE  = 3'd5;

  typedef struct packed {
    logic [2:0] req_type;
    logic [7:0] grid_sel;
    logic [7:0] level;
    logic [7:0] blink_column;
    logic       blink_on;
    logic       fill_on;
    logic [5:0] position;
    logic [2:0] byte_slot;
    logic [7:0] byte_value;
  } req_t;

  typedef struct packed {
    logic [7:0] shift_byte;
    logic       last_byte;
    logic [6:0] pwm_compare;
    logic       flush_done;
    logic       fill_done;
  } res_t;

  // Operations after classification by the front.
  typedef enum logic [2:0] {
    OP_TICK,
    OP_FLUSH,
    OP_BRIGHT,
    OP_BRIGHT_ALL,
    OP_BLINK,
    OP_FILL,
    OP_WRITE
  } op_t;

  typedef struct packed {
    op_t                   op;
    logic [GRID_IDX_W-1:0] grid;
    logic [BRIGHT_W-1:0]   level;
    logic [7:0]            data;
    logic [2:0]            slot;
    logic                  flag;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

endpackage

@@ hw/rtl/vfd_grid_scan_refresher.sv @@
// ----------------------------------------------------------------------------
// vfd_grid_scan_refresher
// Refresh engine for a multiplexed display: edits a user frame, copies it to
// the display frame on request and emits one grid's shift word per tick.
// ----------------------------------------------------------------------------
// Usage:
//   A request word on req is taken at a clock edge where start is high and
//   busy is low. busy rises only when the four-entry command queue is full;
//   requests that change nothing are taken and dropped at once.
//   Results appear on result for one cycle each, marked by strobe. There is
//   no back-pressure: the receiver must take every result word.
//   With an empty queue, the first result of a tick reaches result through the
//   queue, the pop in the idle state, the display frame read and the result
//   register; its words follow on consecutive cycles (ten at the default
//   geometry, last_byte on the final one). In the back end, a tick with a
//   flush pending first copies the user frame to the display frame, sweeping
//   the frame one row per cycle through a single port. A fill gives one
//   result word when done; a brightness write to all grids sweeps every grid,
//   a byte or blink write passes through the edit state, and a flush or a
//   single brightness write is done in the idle state.
//   Reset (synchronous, active high) empties the queue, clears the frames to
//   blank, sets every brightness to 100 and restarts the scan at grid 0.
// ----------------------------------------------------------------------------
module vfd_grid_scan_refresher
  import vfdr_pkg::*;
#(
  parameter int NUM_GRIDS      = DEF_NUM_GRIDS,
  parameter int BYTES_PER_GRID = DEF_BYTES_PER_GRID
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  req_t req,
  output logic strobe,
  output res_t result
);

  q_status_t q_status;
  logic      push;
  logic      pop;
  cmd_t      push_cmd;
  cmd_t      head;

  // Front end: accept and classify.
  vfdr_front #(
    .NUM_GRIDS      (NUM_GRIDS),
    .BYTES_PER_GRID (BYTES_PER_GRID)
  ) u_front (
    .start    (start),
    .busy     (busy),
    .req      (req),
    .q_status (q_status),
    .push     (push),
    .cmd      (push_cmd)
  );

  // Command queue.
  vfdr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wdata    (push_cmd),
    .pop      (pop),
    .head     (head),
    .q_status (q_status)
  );

  // Back end: execute and emit results.
  vfdr_back #(
    .NUM_GRIDS      (NUM_GRIDS),
    .BYTES_PER_GRID (BYTES_PER_GRID)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_status (q_status),
    .head     (head),
    .pop      (pop),
    .strobe   (strobe),
    .result   (result)
  );

endmodule

@@ hw/rtl/vfdr_front.sv @@
// ----------------------------------------------------------------------------
// vfdr_front
// Accepts request words, checks their ranges and turns the ones that have an
// effect into commands for the queue.
// ----------------------------------------------------------------------------
module vfdr_front
  import vfdr_pkg::*;
#(
  parameter int NUM_GRIDS      = DEF_NUM_GRIDS,
  parameter int BYTES_PER_GRID = DEF_BYTES_PER_GRID
) (
  input  logic      start,
  output logic      busy,
  input  req_t      req,
  input  q_status_t q_status,
  output logic      push,
  output cmd_t      cmd
);

  localparam int HALF       = NUM_GRIDS / 2;
  localparam int BLINK_COLS = NUM_GRIDS - HALF;

  logic       keep;
  logic [6:0] lvl_sat;

  // The front stalls only when the queue has no room.
  assign busy = q_status.full;
  assign push = start && !q_status.full && keep;

  assign lvl_sat = (req.level > BRIGHT_MAX8) ? BRIGHT_RESET : req.level[6:0];

  // Classify the word; requests that change nothing are dropped here.
  always_comb begin
    keep      = 1'b0;
    cmd.op    = OP_TICK;
    cmd.grid  = '0;
    cmd.level = lvl_sat;
    cmd.data  = req.byte_value;
    cmd.slot  = req.byte_slot;
    cmd.flag  = 1'b0;
    case (req.req_type)
      REQ_TICK: begin
        keep   = 1'b1;
        cmd.op = OP_TICK;
      end
      REQ_FLUSH: begin
        keep   = 1'b1;
        cmd.op = OP_FLUSH;
      end
      REQ_BRIGHT: begin
        if (req.grid_sel < 8'(NUM_GRIDS)) begin
          keep     = 1'b1;
          cmd.op   = OP_BRIGHT;
          cmd.grid = req.grid_sel[GRID_IDX_W-1:0];
        end else if (req.grid_sel == ALL_GRIDS) begin
          keep   = 1'b1;
          cmd.op = OP_BRIGHT_ALL;
        end
      end
      REQ_BLINK: begin
        if (req.blink_column < 8'(BLINK_COLS)) begin
          keep     = 1'b1;
          cmd.op   = OP_BLINK;
          cmd.grid = GRID_IDX_W'(req.blink_column) + GRID_IDX_W'(HALF);
          cmd.flag = req.blink_on;
        end
      end
      REQ_FILL: begin
        keep     = 1'b1;
        cmd.op   = OP_FILL;
        cmd.flag = req.fill_on;
      end
      REQ_WRITE: begin
        if (({1'b0, req.position} < 7'(NUM_GRIDS)) &&
            ({1'b0, req.byte_slot} < 4'(BYTES_PER_GRID))) begin
          keep     = 1'b1;
          cmd.op   = OP_WRITE;
          cmd.grid = req.position;
        end
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

endmodule

@@ hw/rtl/vfdr_queue.sv @@
// ----------------------------------------------------------------------------
// vfdr_queue
// Short first-in first-out queue of commands between the front and the back.
// ----------------------------------------------------------------------------
module vfdr_queue
  import vfdr_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  cmd_t      wdata,
  input  logic      pop,
  output cmd_t      head,
  output q_status_t q_status
);

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  cmd_t          slots [QUEUE_DEPTH];
  logic [AW-1:0] rd_ptr;
  logic [AW-1:0] wr_ptr;
  logic [CW-1:0] count;

  assign head           = slots[rd_ptr];
  assign q_status.empty = (count == '0);
  assign q_status.full  = (count == CW'(QUEUE_DEPTH));

  // Storage for queued commands.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wdata;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ hw/rtl/vfdr_back.sv @@
// ----------------------------------------------------------------------------
// vfdr_back
// Carries out queued commands: frame edits, fill and copy sweeps, brightness
// updates and the per-tick shift word, and drives the result register.
// ----------------------------------------------------------------------------
module vfdr_back
  import vfdr_pkg::*;
#(
  parameter int NUM_GRIDS      = DEF_NUM_GRIDS,
  parameter int BYTES_PER_GRID = DEF_BYTES_PER_GRID
) (
  input  logic      clk,
  input  logic      rst,
  input  q_status_t q_status,
  input  cmd_t      head,
  output logic      pop,
  output logic      strobe,
  output res_t      result
);

  localparam int GW        = (NUM_GRIDS > 1) ? $clog2(NUM_GRIDS) : 1;
  localparam int CW        = $clog2(NUM_GRIDS + 1);
  localparam int RW        = BYTES_PER_GRID * 8;
  localparam int SEL_BYTES = (NUM_GRIDS + 7) / 8;
  localparam int NB        = SEL_BYTES + BYTES_PER_GRID;
  localparam int KW        = $clog2(NB);

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_EDIT     = 7'b0000010,
    S_FILL     = 7'b0000100,
    S_COPY     = 7'b0001000,
    S_BALL     = 7'b0010000,
    S_TICK_RD  = 7'b0100000,
    S_TICK_OUT = 7'b1000000
  } state_t;

  state_t        state;
  state_t        state_next;
  cmd_t          cmd;
  logic [CW-1:0] ctr;
  logic          pipe_v;
  logic [GW-1:0] pipe_addr;
  logic [GW-1:0] scan;
  logic          flush_pending;
  logic          flushed;
  logic [KW-1:0] k;

  // Frame and brightness stores, with a valid bit per row.
  logic [RW-1:0]       user_mem   [NUM_GRIDS];
  logic [RW-1:0]       disp_mem   [NUM_GRIDS];
  logic [BRIGHT_W-1:0] bright_mem [NUM_GRIDS];
  logic [NUM_GRIDS-1:0] user_ok;
  logic [NUM_GRIDS-1:0] disp_ok;
  logic [NUM_GRIDS-1:0] bright_ok;

  logic                user_we;
  logic [GW-1:0]       user_wa;
  logic [RW-1:0]       user_wd;
  logic [GW-1:0]       user_ra;
  logic [RW-1:0]       user_rd;
  logic                user_rd_ok;
  logic                disp_we;
  logic [GW-1:0]       disp_wa;
  logic [RW-1:0]       disp_wd;
  logic                disp_re;
  logic [RW-1:0]       disp_rd;
  logic                disp_rd_ok;
  logic                bright_we;
  logic [GW-1:0]       bright_wa;
  logic [BRIGHT_W-1:0] bright_wd;
  logic [BRIGHT_W-1:0] bright_rd;
  logic                bright_rd_ok;

  logic [RW-1:0]       user_row;
  logic [RW-1:0]       disp_row;
  logic [BRIGHT_W-1:0] bright_val;
  logic [RW-1:0]       fill_row;
  logic [RW-1:0]       edit_row;
  logic [GW-1:0]       grid_now;
  logic [GW-1:0]       mirror;
  logic [7:0]          grid_x;
  logic [7:0]          tick_byte;
  logic                last_k;
  logic                sweep_issue;
  logic                fill_fin;
  res_t                tick_res;

  // Rows that were never written read as their reset contents.
  assign user_row   = user_rd_ok ? user_rd : '0;
  assign disp_row   = disp_rd_ok ? disp_rd : '0;
  assign bright_val = bright_rd_ok ? bright_rd : BRIGHT_RESET;

  // Interleaved scan order: even steps walk up from grid 0, odd steps down.
  assign grid_now = scan[0] ? (GW'(NUM_GRIDS - 1) - (scan >> 1)) : (scan >> 1);
  assign mirror   = GW'(NUM_GRIDS - 1) - grid_now;
  assign grid_x   = 8'(grid_now);

  assign sweep_issue = (ctr != CW'(NUM_GRIDS));
  assign last_k      = (k == KW'(NB - 1));
  assign fill_fin    = (state == S_FILL) && !sweep_issue;

  // Fill rewrites a row; a blank fill keeps only the blink bit of byte zero.
  always_comb begin
    fill_row = {{(RW - 8){cmd.flag}}, (cmd.flag ? FILL_LIT_BYTE0
                                                : (user_row[7:0] & BLINK_MASK))};
  end

  // Single byte write or blink bit change on the row read for this command.
  always_comb begin
    edit_row = user_row;
    if (cmd.op == OP_WRITE) begin
      edit_row[{cmd.slot, 3'b000} +: 8] = cmd.data;
    end else begin
      edit_row[BLINK_BIT] = cmd.flag;
    end
  end

  // Byte k of the shift word: one-hot grid select bytes, then the frame row.
  always_comb begin
    tick_byte = 8'h00;
    for (int i = 0; i < SEL_BYTES; i++) begin
      if (k == KW'(i)) begin
        tick_byte = (grid_x[7:3] == 5'(i)) ? (GRID_SEL_MSB >> grid_x[2:0]) : 8'h00;
      end
    end
    for (int i = 0; i < BYTES_PER_GRID; i++) begin
      if (k == KW'(SEL_BYTES + i)) begin
        tick_byte = disp_row[i*8 +: 8];
      end
    end
  end

  always_comb begin
    tick_res.shift_byte  = tick_byte;
    tick_res.last_byte   = last_k;
    tick_res.pwm_compare = PWM_TOP - bright_val;
    tick_res.flush_done  = flushed;
    tick_res.fill_done   = 1'b0;
  end

  // Sequencer decode and memory port control.
  always_comb begin
    state_next = state;
    pop        = 1'b0;
    user_ra    = head.grid[GW-1:0];
    user_we    = 1'b0;
    user_wa    = pipe_addr;
    user_wd    = fill_row;
    disp_we    = 1'b0;
    disp_wa    = pipe_addr;
    disp_wd    = user_row;
    disp_re    = 1'b0;
    bright_we  = 1'b0;
    bright_wa  = head.grid[GW-1:0];
    bright_wd  = head.level;
    case (state)
      S_IDLE: begin
        if (!q_status.empty) begin
          pop = 1'b1;
          case (head.op)
            OP_TICK:       state_next = flush_pending ? S_COPY : S_TICK_RD;
            OP_FLUSH:      state_next = S_IDLE;
            OP_BRIGHT:     bright_we  = 1'b1;
            OP_BRIGHT_ALL: state_next = S_BALL;
            OP_BLINK:      state_next = S_EDIT;
            OP_WRITE:      state_next = S_EDIT;
            OP_FILL:       state_next = S_FILL;
            default:       state_next = S_IDLE;
          endcase
        end
      end
      S_EDIT: begin
        user_we    = 1'b1;
        user_wa    = cmd.grid[GW-1:0];
        user_wd    = edit_row;
        state_next = S_IDLE;
      end
      S_FILL: begin
        user_ra = sweep_issue ? ctr[GW-1:0] : '0;
        user_we = pipe_v;
        if (!sweep_issue) begin
          state_next = S_IDLE;
        end
      end
      S_COPY: begin
        user_ra = sweep_issue ? ctr[GW-1:0] : '0;
        disp_we = pipe_v;
        if (!sweep_issue) begin
          state_next = S_TICK_RD;
        end
      end
      S_BALL: begin
        bright_we = 1'b1;
        bright_wa = ctr[GW-1:0];
        bright_wd = cmd.level;
        if (ctr == CW'(NUM_GRIDS - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_TICK_RD: begin
        disp_re    = 1'b1;
        state_next = S_TICK_OUT;
      end
      S_TICK_OUT: begin
        if (last_k) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // User frame store.
  always_ff @(posedge clk) begin
    if (user_we) begin
      user_mem[user_wa] <= user_wd;
    end
    user_rd <= user_mem[user_ra];
  end

  // Display frame store.
  always_ff @(posedge clk) begin
    if (disp_we) begin
      disp_mem[disp_wa] <= disp_wd;
    end
    if (disp_re) begin
      disp_rd <= disp_mem[grid_now];
    end
  end

  // Brightness store.
  always_ff @(posedge clk) begin
    if (bright_we) begin
      bright_mem[bright_wa] <= bright_wd;
    end
    if (disp_re) begin
      bright_rd <= bright_mem[mirror];
    end
  end

  // Row valid bits, cleared by reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      user_ok   <= '0;
      disp_ok   <= '0;
      bright_ok <= '0;
    end else begin
      if (user_we) begin
        user_ok[user_wa] <= 1'b1;
      end
      if (disp_we) begin
        disp_ok[disp_wa] <= 1'b1;
      end
      if (bright_we) begin
        bright_ok[bright_wa] <= 1'b1;
      end
    end
  end

  // Valid bits travel with the registered read data.
  always_ff @(posedge clk) begin
    user_rd_ok <= user_ok[user_ra];
    if (disp_re) begin
      disp_rd_ok   <= disp_ok[grid_now];
      bright_rd_ok <= bright_ok[mirror];
    end
  end

  // Command held while it is carried out.
  always_ff @(posedge clk) begin
    if (pop) begin
      cmd <= head;
    end
  end

  // Sequencer state, sweep counter, scan position and flush bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      ctr           <= '0;
      pipe_v        <= 1'b0;
      scan          <= '0;
      flush_pending <= 1'b0;
      flushed       <= 1'b0;
      k             <= '0;
      strobe        <= 1'b0;
    end else begin
      state  <= state_next;
      strobe <= 1'b0;
      pipe_v <= 1'b0;
      case (state)
        S_IDLE: begin
          ctr <= '0;
          k   <= '0;
          if (!q_status.empty) begin
            if (head.op == OP_FLUSH) begin
              flush_pending <= 1'b1;
            end
            if (head.op == OP_TICK) begin
              flushed       <= flush_pending;
              flush_pending <= 1'b0;
            end
          end
        end
        S_FILL, S_COPY: begin
          if (sweep_issue) begin
            ctr    <= ctr + 1'b1;
            pipe_v <= 1'b1;
          end
          if (fill_fin) begin
            strobe <= 1'b1;
          end
        end
        S_BALL: begin
          ctr <= ctr + 1'b1;
        end
        S_TICK_OUT: begin
          strobe <= 1'b1;
          k      <= k + 1'b1;
          if (last_k) begin
            scan <= (scan == GW'(NUM_GRIDS - 1)) ? '0 : scan + 1'b1;
          end
        end
        default: begin
          ctr <= ctr;
        end
      endcase
    end
  end

  // Address of the row whose read data arrives next cycle during a sweep.
  always_ff @(posedge clk) begin
    pipe_addr <= ctr[GW-1:0];
  end

  // Result word.
  always_ff @(posedge clk) begin
    if (state == S_TICK_OUT) begin
      result <= tick_res;
    end else if (fill_fin) begin
      result.shift_byte  <= 8'h00;
      result.last_byte   <= 1'b0;
      result.pwm_compare <= 7'd0;
      result.flush_done  <= 1'b0;
      result.fill_done   <= 1'b1;
    end
  end

endmodule

@@ hw/rtl/vfdr_checker.sv @@
// ----------------------------------------------------------------------------
// vfdr_checker
// Port-level checks on the refresher's result stream, bound to the top level.
// ----------------------------------------------------------------------------
module vfdr_checker
  import vfdr_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input req_t req,
  input logic strobe,
  input res_t result
);

  // No result word leaves the block in the cycle after reset.
  a_quiet_after_reset: assert property (@(posedge clk)
    rst |=> !strobe)
    else $error("result word shown straight after reset");

  // A fill acknowledge carries nothing but its done flag.
  a_fill_word_clean: assert property (@(posedge clk) disable iff (rst)
    (strobe && result.fill_done) |->
      (result.shift_byte == 8'h00) && !result.last_byte &&
      (result.pwm_compare == 7'd0) && !result.flush_done)
    else $error("fill acknowledge word has stray fields");

  // Tick words carry a compare value within the brightness range.
  a_pwm_range: assert property (@(posedge clk) disable iff (rst)
    (strobe && !result.fill_done) |->
      (result.pwm_compare >= 7'd15) && (result.pwm_compare <= PWM_TOP))
    else $error("blanking compare out of range");

  // The words of one tick follow back to back with the same compare and flag.
  a_tick_burst: assert property (@(posedge clk) disable iff (rst)
    (strobe && !result.fill_done && !result.last_byte) |=>
      strobe && !result.fill_done && $stable(result.pwm_compare) &&
      $stable(result.flush_done))
    else $error("tick words broken up or changed mid-tick");

  // Every request field is seen when a word is taken; none may be unknown.
  a_req_known: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> !$isunknown(req))
    else $error("request word taken with unknown bits");

endmodule

bind vfd_grid_scan_refresher vfdr_checker u_vfdr_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .req    (req),
  .strobe (strobe),
  .result (result)
);

@@ test/vfd_refresh_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vfd_refresh_checker
// Watches the request and result channels of the grid scan refresher. It keeps
// its own copy of the frames, the brightness table and the scan position, and
// works out the result words of every accepted request. Each result word is
// checked field by field against the oldest word still due.
// ----------------------------------------------------------------------------
module vfd_refresh_checker
  import vfdr_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic busy,
  input  req_t req,
  input  logic strobe,
  input  res_t result,
  output int   mismatches,
  output int   words_due
);

  localparam int NUM_GRIDS      = DEF_NUM_GRIDS;
  localparam int BYTES_PER_GRID = DEF_BYTES_PER_GRID;
  localparam int SEL_BYTES      = (NUM_GRIDS + 7) / 8;
  localparam int MAX_REPORTS    = 10;

  // Mirror of the block's state.
  logic [7:0] disp_frame [NUM_GRIDS][BYTES_PER_GRID];
  logic [7:0] user_frame [NUM_GRIDS][BYTES_PER_GRID];
  logic [6:0] grid_level [NUM_GRIDS];
  logic [5:0] scan_pos;
  logic       flush_armed;

  // Result words still to arrive, oldest first.
  res_t due_words [$];
  int   error_count = 0;

  // Put the mirrored state back to its state after reset.
  function automatic void clear_state();
    for (int g = 0; g < NUM_GRIDS; g++) begin
      for (int b = 0; b < BYTES_PER_GRID; b++) begin
        disp_frame[g][b] = 8'h00;
        user_frame[g][b] = 8'h00;
      end
      grid_level[g] = BRIGHT_RESET;
    end
    scan_pos    = '0;
    flush_armed = 1'b0;
    due_words.delete();
  endfunction

  // One tick: optional frame copy, then the shift word of the scanned grid.
  function automatic void predict_tick();
    logic       flushed;
    int         idx;
    int         grid;
    int         lvl;
    int         n;
    logic [6:0] pwm;
    res_t       w;
    flushed = flush_armed;
    if (flush_armed) begin
      disp_frame  = user_frame;
      flush_armed = 1'b0;
    end
    idx = (scan_pos >= NUM_GRIDS) ? 0 : int'(scan_pos);
    // Interleaved order: even steps walk up from grid 0, odd ones down from the top.
    grid = (idx % 2 == 0) ? idx / 2 : NUM_GRIDS - 1 - idx / 2;
    lvl  = grid_level[NUM_GRIDS - 1 - grid];
    if (lvl > BRIGHT_MAX8) begin
      lvl = BRIGHT_MAX8;
    end
    pwm = PWM_TOP - 7'(lvl);
    n   = SEL_BYTES + BYTES_PER_GRID;
    for (int k = 0; k < n; k++) begin
      w = '0;
      if (k < SEL_BYTES) begin
        w.shift_byte = (k == grid / 8) ? (GRID_SEL_MSB >> (grid % 8)) : 8'h00;
      end else begin
        w.shift_byte = disp_frame[grid][k - SEL_BYTES];
      end
      w.last_byte   = (k == n - 1);
      w.pwm_compare = pwm;
      w.flush_done  = flushed;
      due_words.push_back(w);
    end
    scan_pos = (idx + 1 >= NUM_GRIDS) ? '0 : 6'(idx + 1);
  endfunction

  // Apply one accepted request word to the mirrored state.
  function automatic void predict_request(input req_t w);
    logic [7:0] lvl;
    int         g;
    res_t       ack;
    case (w.req_type)
      REQ_TICK: begin
        predict_tick();
      end
      REQ_FLUSH: begin
        flush_armed = 1'b1;
      end
      REQ_BRIGHT: begin
        lvl = (w.level > BRIGHT_MAX8) ? BRIGHT_MAX8 : w.level;
        if (w.grid_sel < NUM_GRIDS) begin
          grid_level[w.grid_sel] = lvl[6:0];
        end else if (w.grid_sel == ALL_GRIDS) begin
          for (int i = 0; i < NUM_GRIDS; i++) begin
            grid_level[i] = lvl[6:0];
          end
        end
      end
      REQ_BLINK: begin
        if (w.blink_column < NUM_GRIDS - NUM_GRIDS / 2) begin
          g = int'(w.blink_column) + NUM_GRIDS / 2;
          if (w.blink_on) begin
            user_frame[g][0] = user_frame[g][0] | BLINK_MASK;
          end else begin
            user_frame[g][0] = user_frame[g][0] & ~BLINK_MASK;
          end
        end
      end
      REQ_FILL: begin
        for (int i = 0; i < NUM_GRIDS; i++) begin
          user_frame[i][0] = w.fill_on ? FILL_LIT_BYTE0 : (user_frame[i][0] & BLINK_MASK);
          for (int b = 1; b < BYTES_PER_GRID; b++) begin
            user_frame[i][b] = w.fill_on ? 8'hFF : 8'h00;
          end
        end
        ack           = '0;
        ack.fill_done = 1'b1;
        due_words.push_back(ack);
      end
      REQ_WRITE: begin
        if (w.position < NUM_GRIDS && w.byte_slot < BYTES_PER_GRID) begin
          user_frame[w.position][w.byte_slot] = w.byte_value;
        end
      end
      default: begin
      end
    endcase
  endfunction

  // Compare a result word with the oldest one due.
  function automatic void check_word(input res_t got);
    res_t want;
    if (due_words.size() == 0) begin
      error_count++;
      if (error_count <= MAX_REPORTS) begin
        $display("%0t: unexpected result word: byte %02h last %0b pwm %0d flush %0b fill %0b",
                 $time, got.shift_byte, got.last_byte, got.pwm_compare, got.flush_done,
                 got.fill_done);
      end
    end else begin
      want = due_words.pop_front();
      if (got.shift_byte !== want.shift_byte || got.last_byte !== want.last_byte ||
          got.pwm_compare !== want.pwm_compare || got.flush_done !== want.flush_done ||
          got.fill_done !== want.fill_done) begin
        error_count++;
        if (error_count <= MAX_REPORTS) begin
          $display("%0t: result mismatch: expected byte %02h last %0b pwm %0d flush %0b fill %0b",
                   $time, want.shift_byte, want.last_byte, want.pwm_compare, want.flush_done,
                   want.fill_done);
          $display("%0t:                   got byte %02h last %0b pwm %0d flush %0b fill %0b",
                   $time, got.shift_byte, got.last_byte, got.pwm_compare, got.flush_done,
                   got.fill_done);
        end
      end
    end
  endfunction

  // Sample both channels at the rising edge.
  always @(posedge clk) begin
    if (rst) begin
      clear_state();
    end else begin
      if (strobe) begin
        check_word(result);
      end
      if (start && !busy) begin
        predict_request(req);
      end
    end
    mismatches <= error_count;
    words_due  <= due_words.size();
  end

endmodule

@@ test/vfd_grid_scan_refresher_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vfd_grid_scan_refresher_tb
// Drives request words into the grid scan refresher: a directed set over the
// edges of every request, then random phases of mostly well-formed edit,
// flush and tick traffic with random idle gaps. The checker beside the block
// predicts and checks every result word; this module gives the verdict.
// ----------------------------------------------------------------------------
module vfd_grid_scan_refresher_tb;
  import vfdr_pkg::*;

  // Request codes the block ignores.
  localparam logic [2:0] REQ_SPARE6 = 3'd6;
  localparam logic [2:0] REQ_SPARE7 = 3'd7;

  localparam int PHASES          = 5;
  localparam int WORDS_PER_PHASE = 89;
  localparam int SETTLE_CYCLES   = 64;

  logic clk;
  logic rst   = 1'b1;
  logic start = 1'b0;
  logic busy;
  req_t req   = '0;
  logic strobe;
  res_t result;
  int   fail_count;
  int   words_due;
  bit   no_idle = 1'b0;

  vfd_grid_scan_refresher DUT (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .req    (req),
    .strobe (strobe),
    .result (result)
  );

  vfd_refresh_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .req        (req),
    .strobe     (strobe),
    .result     (result),
    .mismatches (fail_count),
    .words_due  (words_due)
  );

  // 10 ns clock.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Build a request word from its fields.
  function automatic req_t make_word(input logic [2:0] code, input logic [7:0] gsel,
                                     input logic [7:0] lvl, input logic [7:0] col,
                                     input logic bon, input logic fon, input logic [5:0] pos,
                                     input logic [2:0] slot, input logic [7:0] val);
    req_t w;
    w.req_type     = code;
    w.grid_sel     = gsel;
    w.level        = lvl;
    w.blink_column = col;
    w.blink_on     = bon;
    w.fill_on      = fon;
    w.position     = pos;
    w.byte_slot    = slot;
    w.byte_value   = val;
    return w;
  endfunction

  // Random request word: all fields random, the ones in use mostly in range.
  function automatic req_t random_word();
    logic [63:0] raw;
    req_t        w;
    int          pick;
    raw  = {$urandom(), $urandom()};
    w    = raw[$bits(req_t)-1:0];
    pick = $urandom_range(0, 99);
    if (pick < 38) begin
      w.req_type = REQ_TICK;
    end else if (pick < 44) begin
      w.req_type = REQ_FLUSH;
    end else if (pick < 54) begin
      w.req_type = REQ_BRIGHT;
    end else if (pick < 63) begin
      w.req_type = REQ_BLINK;
    end else if (pick < 67) begin
      w.req_type = REQ_FILL;
    end else if (pick < 96) begin
      w.req_type = REQ_WRITE;
    end else begin
      w.req_type = ($urandom_range(0, 1) == 0) ? REQ_SPARE6 : REQ_SPARE7;
    end
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      w.grid_sel = 8'($urandom_range(0, 39));
    end else if (pick < 75) begin
      w.grid_sel = ALL_GRIDS;
    end
    if ($urandom_range(0, 99) < 70) begin
      w.level = 8'($urandom_range(0, 100));
    end
    if ($urandom_range(0, 99) < 75) begin
      w.blink_column = 8'($urandom_range(0, 19));
    end
    if ($urandom_range(0, 99) < 85) begin
      w.position = 6'($urandom_range(0, 39));
    end
    if ($urandom_range(0, 99) < 85) begin
      w.byte_slot = 3'($urandom_range(0, 4));
    end
    return w;
  endfunction

  // Present one word, hold it until taken, then idle for a drawn gap.
  task automatic send_word(input req_t w);
    int gap;
    start <= 1'b1;
    req   <= w;
    do begin
      @(posedge clk);
    end while (busy);
    @(negedge clk);
    gap = no_idle ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Stop sending and wait until every due word has come and the block settles.
  task automatic wait_quiet(input int settle);
    start <= 1'b0;
    while (words_due != 0) begin
      @(negedge clk);
    end
    repeat (settle) @(negedge clk);
  endtask

  // Stimulus and verdict.
  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part: edges of every request, starting from the reset state.
    send_word(make_word(REQ_TICK,   8'd0,   8'd0,   8'd0,   1'b0, 1'b0, 6'd0,  3'd0, 8'h00));
    send_word(make_word(REQ_WRITE,  8'd0,   8'd0,   8'd0,   1'b0, 1'b0, 6'd0,  3'd0, 8'hFF));
    send_word(make_word(REQ_WRITE,  8'd255, 8'd255, 8'd255, 1'b1, 1'b1, 6'd39, 3'd4, 8'hA5));
    send_word(make_word(REQ_WRITE,  8'd0,   8'd0,   8'd0,   1'b0, 1'b0, 6'd40, 3'd0, 8'h11));
    send_word(make_word(REQ_WRITE,  8'd0,   8'd0,   8'd0,   1'b0, 1'b0, 6'd63, 3'd7, 8'h22));
    send_word(make_word(REQ_WRITE,  8'd0,   8'd0,   8'd0,   1'b0, 1'b0, 6'd5,  3'd5, 8'h33));
    send_word(make_word(REQ_BLINK,  8'd0,   8'd0,   8'd0,   1'b1, 1'b0, 6'd0,  3'd0, 8'h00));
    send_word(make_word(REQ_BLINK,  8'd0,   8'd0,   8'd19,  1'b1, 1'b0, 6'd0,  3'd0, 8'h00));
    send_word(make_word(REQ_BLINK,  8'd0,   8'd0,   8'd20,  1'b1, 1'b0, 6'd0,  3'd0, 8'h00));
    send_word(make_word(REQ_BLINK,  8'd0,   8'd0,   8'd255, 1'b1, 1'b0, 6'd0,  3'd0, 8'h00));
    // Two flushes before a tick give a single copy.
    send_word(make_word(REQ_FLUSH,  8'd0,   8'd0,   8'd0,   1'b0, 1'b0, 6'd0,  3'd0, 8'h00));
    send_word(make_word(REQ_FLUSH,  8'd0,   8'd0,   8'd0,   1'b0, 1'b0, 6'd0,  3'd0, 8'h00));
    send_word(make_word(REQ_TICK,   8'd0,   8'd0,   8'd0,   1'b0, 1'b0, 6'd0,  3'd0, 8'h00));
    send_word(make_word(REQ_TICK,   8'd0,   8'd0,   8'd0,   1'b0, 1'b0, 6'd0,  3'd0, 8'h00));
    // Brightness: all grids, single grids, saturation and ignored targets.
    send_word(make_word(REQ_BRIGHT, ALL_GRIDS, 8'd50, 8'd0, 1'b0, 1'b0, 6'd0,  3'd0, 8'h00));
    send_word(make_word(REQ_BRIGHT, 8'd0,   8'd0,   8'd0,   1'b0, 1'b0, 6'd0,  3'd0, 8'h00));
    send_word(make_word(REQ_BRIGHT, 8'd39,  8'd255, 8'd0,   1'b0, 1'b0, 6'd0,  3'd0, 8'h00));
    send_word(make_word(REQ_BRIGHT, 8'd40,  8'd7,   8'd0,   1'b0, 1'b0, 6'd0,  3'd0, 8'h00));
    send_word(make_word(REQ_BRIGHT, 8'd255, 8'd9,   8'd0,   1'b0, 1'b0, 6'd0,  3'd0, 8'h00));
    // Fills: lit clears the blink bit, blank keeps it.
    send_word(make_word(REQ_FILL,   8'd0,   8'd0,   8'd0,   1'b0, 1'b1, 6'd0,  3'd0, 8'h00));
    send_word(make_word(REQ_BLINK,  8'd0,   8'd0,   8'd0,   1'b1, 1'b0, 6'd0,  3'd0, 8'h00));
    send_word(make_word(REQ_FILL,   8'd0,   8'd0,   8'd0,   1'b0, 1'b0, 6'd0,  3'd0, 8'h00));
    send_word(make_word(REQ_SPARE6, 8'd99,  8'd0,   8'd0,   1'b1, 1'b1, 6'd1,  3'd1, 8'hFF));
    send_word(make_word(REQ_SPARE7, 8'd99,  8'd0,   8'd0,   1'b1, 1'b1, 6'd1,  3'd1, 8'hFF));
    send_word(make_word(REQ_FLUSH,  8'd0,   8'd0,   8'd0,   1'b0, 1'b0, 6'd0,  3'd0, 8'h00));
    send_word(make_word(REQ_TICK,   8'd0,   8'd0,   8'd0,   1'b0, 1'b0, 6'd0,  3'd0, 8'h00));
    wait_quiet(SETTLE_CYCLES);

    // Random phases; each ends with the sender held off until all words are in.
    for (int p = 0; p < PHASES; p++) begin
      for (int i = 0; i < WORDS_PER_PHASE; i++) begin
        if ($urandom_range(0, 29) == 0) begin
          no_idle = !no_idle;
        end
        send_word(random_word());
      end
      wait_quiet(SETTLE_CYCLES);
    end
    repeat (150) @(negedge clk);

    if (fail_count == 0 && words_due == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #5000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

@@ vfd_grid_scan_refresher.f @@
hw/rtl/vfdr_pkg.sv
hw/rtl/vfdr_front.sv
hw/rtl/vfdr_queue.sv
hw/rtl/vfdr_back.sv
hw/rtl/vfd_grid_scan_refresher.sv
hw/rtl/vfdr_checker.sv
test/vfd_refresh_checker.sv
test/vfd_grid_scan_refresher_tb.sv
